/* rtl/mkrs_pkg.sv */
`default_nettype none
// ============================================================================
// mkrs_pkg
// Shared types, sizes and the sort-order compare for the record rank sorter.
// ============================================================================
package mkrs_pkg;

    localparam int MAX_RECORDS = 16;
    localparam int SCORE_BITS  = 8;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int SUM_W       = SCORE_BITS + 2;
    localparam int POS_W       = 5;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [IDX_W-1:0]      idx;
        logic [SCORE_BITS-1:0] s1;
        logic [SCORE_BITS-1:0] s2;
        logic [SCORE_BITS-1:0] s3;
        logic [SUM_W-1:0]      total;
    } rec_t;

    // One queue entry: a record to place and/or the end-of-set marker.
    typedef struct packed {
        rec_t rec;
        logic store;
        logic last;
        logic ovf;
    } q_entry_t;

    // True when x must come strictly before y.
    function automatic logic ranks_above(input rec_t x, input rec_t y);
        logic res;
        if (x.total != y.total) begin
            res = (x.total > y.total);
        end else if (x.s1 != y.s1) begin
            res = (x.s1 > y.s1);
        end else if (x.s2 != y.s2) begin
            res = (x.s2 > y.s2);
        end else begin
            res = (x.s3 > y.s3);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/mkrs_if.sv */
`default_nettype none
// ============================================================================
// mkrs_in_if / mkrs_out_if
// Valid/ready channels for loaded records and for ranked results.
// ============================================================================
interface mkrs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_score;
    logic [7:0] second_score;
    logic [7:0] third_score;
    logic       last;

    modport source (output valid, first_score, second_score, third_score, last,
                    input ready);
    modport sink   (input valid, first_score, second_score, third_score, last,
                    output ready);
endinterface

interface mkrs_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] load_index;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
    logic [9:0] score_sum;
    logic [4:0] position;
    logic       overflow;
    logic       final_res;

    modport source (output valid, load_index, out_first, out_second, out_third,
                    score_sum, position, overflow, final_res,
                    input ready);
    modport sink   (input valid, load_index, out_first, out_second, out_third,
                    score_sum, position, overflow, final_res,
                    output ready);
endinterface
`default_nettype wire

/* rtl/mkrs_front.sv */
`default_nettype none
// ============================================================================
// mkrs_front
// Accepts records, numbers them, forms the score sum and tracks capacity.
// ============================================================================
module mkrs_front
    import mkrs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    mkrs_in_if.sink       records,
    output logic          push_valid,
    input  wire logic     push_ready,
    output q_entry_t      push_data
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;
    logic             accept;
    logic             has_room;

    assign records.ready = push_ready;
    assign accept        = records.valid && push_ready;
    assign has_room      = (count_reg < CNT_W'(MAX_RECORDS));

    always_comb
    begin
        push_data.rec.idx   = count_reg[IDX_W-1:0];
        push_data.rec.s1    = records.first_score[SCORE_BITS-1:0];
        push_data.rec.s2    = records.second_score[SCORE_BITS-1:0];
        push_data.rec.s3    = records.third_score[SCORE_BITS-1:0];
        push_data.rec.total = SUM_W'(records.first_score[SCORE_BITS-1:0])
                            + SUM_W'(records.second_score[SCORE_BITS-1:0])
                            + SUM_W'(records.third_score[SCORE_BITS-1:0]);
        push_data.store     = has_room;
        push_data.last      = records.last;
        push_data.ovf       = drop_reg || !has_room;
    end

    // A dropped item that is not the last one leaves nothing for the back end.
    assign push_valid = records.valid && (has_room || records.last);

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (accept) begin
            if (records.last) begin
                count_next = '0;
                drop_next  = 1'b0;
            end else if (has_room) begin
                count_next = count_reg + 1'b1;
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/mkrs_queue.sv */
`default_nettype none
// ============================================================================
// mkrs_queue
// Short first-in first-out queue between the front and the sorting chain.
// ============================================================================
module mkrs_queue
    import mkrs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire q_entry_t push_data,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output q_entry_t      pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/mkrs_back.sv */
`default_nettype none
// ============================================================================
// mkrs_back
// Insertion sorting chain: places one record per cycle while it is not shifting
// a run out, then shifts the sorted run out from the head cell with rank and final marker.
// ============================================================================
module mkrs_back
    import mkrs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     pop_valid,
    output logic          pop_ready,
    input  wire q_entry_t pop_data,
    mkrs_out_if.source    results
);

    rec_t             cell_reg  [MAX_RECORDS];
    rec_t             cell_next [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] valid_reg, valid_next;
    logic [MAX_RECORDS-1:0] stay;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             drain_reg, drain_next;
    logic             ovf_reg, ovf_next;
    logic             do_pop, do_ins, do_out;
    logic             is_final;
    rec_t             head;

    assign pop_ready = !drain_reg;
    assign do_pop    = pop_valid && !drain_reg;
    assign do_ins    = do_pop && pop_data.store;
    assign do_out    = results.valid && results.ready;
    assign is_final  = (count_reg == CNT_W'(1));
    assign head      = cell_reg[0];

    assign results.valid      = drain_reg;
    assign results.load_index = head.idx;
    assign results.out_first  = head.s1;
    assign results.out_second = head.s2;
    assign results.out_third  = head.s3;
    assign results.score_sum  = head.total;
    assign results.position   = pos_reg;
    assign results.overflow   = ovf_reg;
    assign results.final_res  = is_final;

    // A cell keeps its record when the new one does not rank above it, so
    // fully equal records stay in load order.
    always_comb
    begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            stay[i] = valid_reg[i] && !ranks_above(pop_data.rec, cell_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            cell_next[i] = cell_reg[i];
        end
        valid_next = valid_reg;

        if (do_ins) begin
            if (!stay[0]) begin
                cell_next[0] = pop_data.rec;
            end
            valid_next[0] = 1'b1;
            for (int i = 1; i < MAX_RECORDS; i++) begin
                if (!stay[i]) begin
                    cell_next[i] = stay[i-1] ? pop_data.rec : cell_reg[i-1];
                end
                valid_next[i] = valid_reg[i] || valid_reg[i-1];
            end
        end else if (do_out) begin
            for (int i = 0; i < MAX_RECORDS - 1; i++) begin
                cell_next[i] = cell_reg[i+1];
            end
            valid_next = {1'b0, valid_reg[MAX_RECORDS-1:1]};
        end
    end

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        drain_next = drain_reg;
        ovf_next   = ovf_reg;
        if (do_pop) begin
            count_next = count_reg + CNT_W'(pop_data.store);
            if (pop_data.last) begin
                drain_next = (count_reg != '0) || pop_data.store;
                ovf_next   = pop_data.ovf;
                pos_next   = POS_W'(1);
            end
        end else if (do_out) begin
            count_next = count_reg - 1'b1;
            pos_next   = pos_reg + 1'b1;
            if (is_final) begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            count_reg <= '0;
            pos_reg   <= POS_W'(1);
            drain_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            drain_reg <= drain_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/multi_key_record_rank_sorter.sv */
`default_nettype none
// ============================================================================
// multi_key_record_rank_sorter
// Loads a set of score records, sorts them by sum and then by each score
// in turn, and returns them ranked, with load index, sum and flags.
// ============================================================================
// Throughput: one record per cycle while the queue has room; results leave one
// per cycle while results.ready is high. The last item goes into the queue,
// then is inserted into the chain behind any items queued before it, which
// starts the output of the run. While a run is output the chain takes nothing;
// the 4-entry queue keeps accepting items of the next set until it fills.
// Reset: asynchronous, clears counts, flags, queue pointers and valid bits and sets the rank to one.
module multi_key_record_rank_sorter
    import mkrs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mkrs_in_if.sink    records,
    mkrs_out_if.source results
);

    logic     push_valid, push_ready;
    logic     pop_valid, pop_ready;
    q_entry_t push_data, pop_data;

    mkrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .records    (records),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mkrs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mkrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .results   (results)
    );

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Testbench for multi_key_record_rank_sorter. Drives sets of score records,
// keeps a model of the stored set, ranks it when the closing record arrives,
// and checks every returned record against the ranking.
// ============================================================================
module tb;

    localparam int CAPACITY       = mkrs_pkg::MAX_RECORDS;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct {
        logic [3:0] idx;
        logic [7:0] s1;
        logic [7:0] s2;
        logic [7:0] s3;
        logic [9:0] total;
    } scored_rec_t;

    typedef struct {
        logic [3:0] load_index;
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        logic [9:0] score_sum;
        logic [4:0] position;
        logic       overflow;
        logic       final_res;
    } ranked_result_t;

    logic clk = 1'b0;
    logic rst_n;

    mkrs_in_if  rec_if ();
    mkrs_out_if res_if ();

    multi_key_record_rank_sorter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .records (rec_if),
        .results (res_if)
    );

    scored_rec_t    loaded_records[$];
    logic           set_overflowed = 1'b0;
    ranked_result_t ranked_results_due[$];

    int mismatch_count = 0;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Descending order over this key is sum first, then each score in turn.
    function automatic logic [33:0] order_key(input scored_rec_t r);
        return {r.total, r.s1, r.s2, r.s3};
    endfunction

    // Stores or drops one accepted record; a closing record ranks the set.
    task automatic record_accepted(input logic [7:0] f, input logic [7:0] s,
                                   input logic [7:0] t, input logic lst);
        scored_rec_t    r;
        scored_rec_t    ranked[$];
        ranked_result_t res;
        int             j;
        if (loaded_records.size() < CAPACITY)
        begin
            r.idx   = 4'(loaded_records.size());
            r.s1    = f;
            r.s2    = s;
            r.s3    = t;
            r.total = {2'b00, f} + {2'b00, s} + {2'b00, t};
            loaded_records.push_back(r);
        end
        else
        begin
            set_overflowed = 1'b1;
        end
        if (lst)
        begin
            // Strict compare keeps fully equal records in load order.
            foreach (loaded_records[i])
            begin
                j = ranked.size();
                while (j > 0 && order_key(loaded_records[i]) > order_key(ranked[j-1]))
                    j--;
                ranked.insert(j, loaded_records[i]);
            end
            foreach (ranked[i])
            begin
                res.load_index = ranked[i].idx;
                res.first      = ranked[i].s1;
                res.second     = ranked[i].s2;
                res.third      = ranked[i].s3;
                res.score_sum  = ranked[i].total;
                res.position   = 5'(i + 1);
                res.overflow   = set_overflowed;
                res.final_res  = (i == ranked.size() - 1);
                ranked_results_due.push_back(res);
            end
            loaded_records.delete();
            set_overflowed = 1'b0;
        end
    endtask

    task automatic compare_field(input string field, input logic [9:0] want,
                                 input logic [9:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        ranked_result_t want;
        if (ranked_results_due.size() == 0)
        begin
            $display("%0t: unexpected item, expected none, actual index %0d sum %0d rank %0d",
                     $time, res_if.load_index, res_if.score_sum, res_if.position);
            mismatch_count++;
        end
        else
        begin
            want = ranked_results_due.pop_front();
            compare_field("load_index", 10'(want.load_index), 10'(res_if.load_index));
            compare_field("out_first", 10'(want.first), 10'(res_if.out_first));
            compare_field("out_second", 10'(want.second), 10'(res_if.out_second));
            compare_field("out_third", 10'(want.third), 10'(res_if.out_third));
            compare_field("score_sum", want.score_sum, res_if.score_sum);
            compare_field("position", 10'(want.position), 10'(res_if.position));
            compare_field("overflow", 10'(want.overflow), 10'(res_if.overflow));
            compare_field("final_res", 10'(want.final_res), 10'(res_if.final_res));
        end
    endtask

    // Result side: check each accepted item, then choose ready for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            check_result();
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((rec_if.valid && rec_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_record(input logic [7:0] f, input logic [7:0] s,
                               input logic [7:0] t, input logic lst);
        while ($urandom_range(99) < idle_pct)
        begin
            rec_if.valid        <= 1'b0;
            rec_if.first_score  <= 8'($urandom);
            rec_if.second_score <= 8'($urandom);
            rec_if.third_score  <= 8'($urandom);
            rec_if.last         <= 1'($urandom);
            @(posedge clk);
        end
        rec_if.valid        <= 1'b1;
        rec_if.first_score  <= f;
        rec_if.second_score <= s;
        rec_if.third_score  <= t;
        rec_if.last         <= lst;
        @(posedge clk);
        while (!rec_if.ready)
            @(posedge clk);
        record_accepted(f, s, t, lst);
    endtask

    function automatic logic [7:0] pick_score();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 8'hFF : 8'h00;
            1: return 8'($urandom_range(3));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_single_extreme();
        send_record(8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    // Equal sums are split by the first score, then the second; equal
    // records must come out in load order.
    task automatic test_tie_breaks();
        send_record(8'd30, 8'd20, 8'd10, 1'b0);
        send_record(8'd10, 8'd20, 8'd30, 1'b0);
        send_record(8'd10, 8'd30, 8'd20, 1'b0);
        send_record(8'd10, 8'd20, 8'd30, 1'b0);
        send_record(8'd0, 8'd0, 8'd0, 1'b0);
        send_record(8'hFF, 8'hFF, 8'hFF, 1'b1);
    endtask

    // A full store, one dropped plain record, then a dropped closing record.
    task automatic test_store_overflow();
        for (int i = 0; i < CAPACITY + 2; i++)
            send_record(8'(i * 16), 8'(255 - i * 15), 8'(i), i == CAPACITY + 1);
    endtask

    // Results are held off while a full set and a following set of ten are offered,
    // so the block must stop taking records.
    task automatic test_output_backpressure();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < CAPACITY; i++)
            send_record(pick_score(), pick_score(), pick_score(), i == CAPACITY - 1);
        for (int i = 0; i < 10; i++)
            send_record(pick_score(), pick_score(), pick_score(), i == 9);
    endtask

    task automatic test_random_sets(input int n_items, input int idle, input int stall);
        int         sent;
        int         roll;
        int         set_size;
        logic [7:0] f;
        logic [7:0] s;
        logic [7:0] t;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 85)
                set_size = $urandom_range(1, 8);
            else if (roll < 95)
                set_size = $urandom_range(9, CAPACITY);
            else
                set_size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
            for (int k = 0; k < set_size; k++)
            begin
                // Now and then repeat the previous record to create full ties.
                if (k == 0 || $urandom_range(99) >= 15)
                begin
                    f = pick_score();
                    s = pick_score();
                    t = pick_score();
                end
                send_record(f, s, t, k == set_size - 1);
            end
            sent += set_size;
        end
    endtask

    initial
    begin
        rec_if.valid        = 1'b0;
        rec_if.first_score  = 8'h00;
        rec_if.second_score = 8'h00;
        rec_if.third_score  = 8'h00;
        rec_if.last         = 1'b0;
        res_if.ready        = 1'b0;
        rst_n               = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_single_extreme();
        test_tie_breaks();
        test_store_overflow();
        test_output_backpressure();
        test_random_sets(70, 0, 0);
        test_random_sets(70, 81, 0);
        test_random_sets(70, 0, 81);
        test_random_sets(70, 6, 6);

        rec_if.valid <= 1'b0;
        @(posedge clk);
        while (ranked_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
